@@ hdl/mxa_pkg.sv @@
// mxa_pkg: shared types, widths and saturation helper for the 4x4 matrix row ALU.
// No dependencies; compiled first.
package mxa_pkg;

    localparam int ELEM_W        = 32;
    localparam int LANES         = 4;
    localparam int ROW_W         = 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int SUM_W         = PROD_W + 2;   // four products summed exactly
    localparam int LIN_W         = ELEM_W + 2;   // add/sub result, with headroom

    typedef enum logic [2:0] {
        OP_LOAD_ROW = 3'd0,
        OP_MULTIPLY = 3'd1,
        OP_ADD_ROW  = 3'd2,
        OP_SUB_ROW  = 3'd3,
        OP_SCALE    = 3'd4,
        OP_BIAS_ADD = 3'd5,
        OP_BIAS_SUB = 3'd6,
        OP_READ_COL = 3'd7
    } t_opcode;

    typedef struct packed {
        t_opcode                    opcode;
        logic [ROW_W-1:0]           row_index;
        logic signed [ELEM_W-1:0]   elem0;
        logic signed [ELEM_W-1:0]   elem1;
        logic signed [ELEM_W-1:0]   elem2;
        logic signed [ELEM_W-1:0]   elem3;
        logic signed [ELEM_W-1:0]   scalar;
    } t_in_beat;

    typedef struct packed {
        logic signed [ELEM_W-1:0]   out0;
        logic signed [ELEM_W-1:0]   out1;
        logic signed [ELEM_W-1:0]   out2;
        logic signed [ELEM_W-1:0]   out3;
        logic [ROW_W-1:0]           out_row;
        logic                       saturated;
    } t_out_beat;

    // control that travels with the product stage
    typedef struct packed {
        t_opcode                    op;
        logic [ROW_W-1:0]           row;
    } t_stage_ctrl;

    // clip a wide signed value to the element range; bit ELEM_W is the clip flag
    function automatic logic [ELEM_W:0] sat_elem(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-ELEM_W:0] hi;
        logic                  fits;
        logic [ELEM_W-1:0]     res;
        hi   = v[SUM_W-1:ELEM_W-1];
        fits = (&hi) | ~(|hi);
        if (fits) begin
            res = v[ELEM_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(ELEM_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(ELEM_W-1){1'b1}}};
        end
        return {~fits, res};
    endfunction

endpackage

@@ hdl/mxa_stream_if.sv @@
// mxa_stream_if: valid/ready stream channel carrying one payload beat.
// Payload type is a parameter; the block uses mxa_pkg beat types.
interface mxa_stream_if #(parameter type T_DATA = logic);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/mxa_sat_sum.sv @@
// mxa_sat_sum: final stage math - column sums of products, fixed-point shift,
// saturation and result select. Depends on mxa_pkg.
module mxa_sat_sum #(
    parameter int FRAC_BITS = mxa_pkg::FRAC_BITS_DEF
) (
    input  mxa_pkg::t_stage_ctrl                    i_ctrl,
    input  logic signed [mxa_pkg::PROD_W-1:0]       i_prod [mxa_pkg::LANES][mxa_pkg::LANES],
    input  logic signed [mxa_pkg::LIN_W-1:0]        i_lin  [mxa_pkg::LANES],
    output mxa_pkg::t_out_beat                      o_beat
);
    import mxa_pkg::*;

    logic signed [SUM_W-1:0]  s_sum  [LANES];
    logic signed [SUM_W-1:0]  s_val  [LANES];
    logic [ELEM_W:0]          s_clip [LANES];
    logic                     s_use_prod;

    // multiply and scale both land here; scale uses only the diagonal products
    assign s_use_prod = (i_ctrl.op == OP_MULTIPLY) || (i_ctrl.op == OP_SCALE);

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            s_sum[j] = SUM_W'(i_prod[0][j]) + SUM_W'(i_prod[1][j])
                     + SUM_W'(i_prod[2][j]) + SUM_W'(i_prod[3][j]);
            // arithmetic shift == floor division by 2^FRAC_BITS
            s_val[j]  = s_use_prod ? (s_sum[j] >>> FRAC_BITS) : SUM_W'(i_lin[j]);
            s_clip[j] = sat_elem(s_val[j]);
        end
    end

    always_comb begin
        o_beat.out0      = s_clip[0][ELEM_W-1:0];
        o_beat.out1      = s_clip[1][ELEM_W-1:0];
        o_beat.out2      = s_clip[2][ELEM_W-1:0];
        o_beat.out3      = s_clip[3][ELEM_W-1:0];
        o_beat.out_row   = i_ctrl.row;
        o_beat.saturated = s_clip[0][ELEM_W] | s_clip[1][ELEM_W]
                         | s_clip[2][ELEM_W] | s_clip[3][ELEM_W];
    end
endmodule

@@ hdl/matrix4x4_row_alu.sv @@
// matrix4x4_row_alu: top level of the 4x4 Q-format matrix row ALU.
// Depends on mxa_pkg, mxa_stream_if and mxa_sat_sum.
//
//   channel | dir | beat type  | carries
//   --------+-----+------------+------------------------------------------
//   i_in    | in  | t_in_beat  | opcode, row_index, elem0..3, scalar
//   o_out   | out | t_out_beat | out0..3, out_row, saturated
//
// One beat per cycle sustained while o_out.ready stays high; a result beat
// passes input reg -> product reg -> output reg, then o_out.valid rises and
// the beat goes out once o_out.ready is high. The product stage
// (sixteen 32x32 multipliers) and the column-sum/saturate stage set the cycle time.
// A load row beat writes the stored matrix at accept and yields no result;
// the next beat already sees the new row.
// Reset (sync, active low) clears the pipeline valids and the stored matrix;
// no clearing pass.
// Stalls: o_out.ready feeds back through the stage valids to i_in.ready, so
// empty stages keep filling while a finished beat waits at the output.
module matrix4x4_row_alu #(
    parameter int FRAC_BITS = mxa_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mxa_stream_if.sink    i_in,
    mxa_stream_if.source  o_out
);
    import mxa_pkg::*;

    // stored matrix, row-major
    logic signed [ELEM_W-1:0] r_mat [LANES][LANES];

    // stage A: input register
    logic                     r_a_vld;
    t_stage_ctrl              r_a_ctrl;
    logic signed [ELEM_W-1:0] r_a_elem [LANES];
    logic signed [ELEM_W-1:0] r_a_scalar;

    // stage B: product register
    logic                     r_b_vld;
    t_stage_ctrl              r_b_ctrl;
    logic signed [PROD_W-1:0] r_b_prod [LANES][LANES];
    logic signed [LIN_W-1:0]  r_b_lin  [LANES];

    // stage C: output register
    logic                     r_c_vld;
    t_out_beat                r_c_beat;

    // next values of stage B
    logic signed [PROD_W-1:0] n_prod [LANES][LANES];
    logic signed [LIN_W-1:0]  n_lin  [LANES];
    logic signed [ELEM_W-1:0] s_mul_b [LANES][LANES];
    logic signed [ELEM_W-1:0] s_in_elem [LANES];
    t_out_beat                s_c_next;

    logic c_take, b_free, a_free, b_go, a_go, in_beat, in_load;

    // ---------------- flow control ----------------
    assign c_take  = !r_c_vld || o_out.ready;
    assign b_go    = r_b_vld && c_take;
    assign b_free  = !r_b_vld || c_take;
    assign a_go    = r_a_vld && b_free;
    assign a_free  = !r_a_vld || b_free;

    // a beat is taken only when stage A is empty or moving on, so a load
    // never overwrites the matrix under a held beat that still reads it
    assign i_in.ready = a_free;
    assign in_beat    = i_in.valid && a_free;
    assign in_load    = in_beat && (i_in.data.opcode == OP_LOAD_ROW);

    assign s_in_elem[0] = i_in.data.elem0;
    assign s_in_elem[1] = i_in.data.elem1;
    assign s_in_elem[2] = i_in.data.elem2;
    assign s_in_elem[3] = i_in.data.elem3;

    // ---------------- stored matrix ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANES; k++) begin
                for (int j = 0; j < LANES; j++) begin
                    r_mat[k][j] <= '0;
                end
            end
        end else if (in_load) begin
            for (int j = 0; j < LANES; j++) begin
                r_mat[i_in.data.row_index][j] <= s_in_elem[j];
            end
        end
    end

    // ---------------- stage A ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_free) begin
            // loads retire at accept; only result-bearing beats enter
            r_a_vld <= in_beat && !in_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a_ctrl.op  <= i_in.data.opcode;
            r_a_ctrl.row <= i_in.data.row_index;
            r_a_elem     <= s_in_elem;
            r_a_scalar   <= i_in.data.scalar;
        end
    end

    // products: multiply uses the matrix, scale puts the scalar on the
    // diagonal so the same column sums give elem_j * scalar
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            for (int j = 0; j < LANES; j++) begin
                if (r_a_ctrl.op == OP_SCALE) begin
                    s_mul_b[k][j] = (k == j) ? r_a_scalar : '0;
                end else begin
                    s_mul_b[k][j] = r_mat[k][j];
                end
                n_prod[k][j] = PROD_W'(r_a_elem[k]) * PROD_W'(s_mul_b[k][j]);
            end
        end
    end

    // add/sub/bias/column read, exact in LIN_W bits
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            unique case (r_a_ctrl.op)
                OP_ADD_ROW:  n_lin[j] = LIN_W'(r_a_elem[j]) + LIN_W'(r_mat[r_a_ctrl.row][j]);
                OP_SUB_ROW:  n_lin[j] = LIN_W'(r_a_elem[j]) - LIN_W'(r_mat[r_a_ctrl.row][j]);
                OP_BIAS_ADD: n_lin[j] = LIN_W'(r_a_elem[j]) + LIN_W'(r_a_scalar);
                OP_BIAS_SUB: n_lin[j] = LIN_W'(r_a_elem[j]) - LIN_W'(r_a_scalar);
                OP_READ_COL: n_lin[j] = LIN_W'(r_mat[j][r_a_ctrl.row]);
                OP_LOAD_ROW,
                OP_MULTIPLY,
                OP_SCALE:    n_lin[j] = '0;
            endcase
        end
    end

    // ---------------- stage B ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (b_free) begin
            r_b_vld <= a_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free) begin
            r_b_ctrl <= r_a_ctrl;
            r_b_prod <= n_prod;
            r_b_lin  <= n_lin;
        end
    end

    mxa_sat_sum #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat_sum (
        .i_ctrl (r_b_ctrl),
        .i_prod (r_b_prod),
        .i_lin  (r_b_lin),
        .o_beat (s_c_next)
    );

    // ---------------- stage C ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (c_take) begin
            r_c_vld <= b_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_take) begin
            r_c_beat <= s_c_next;
        end
    end

    assign o_out.valid = r_c_vld;
    assign o_out.data  = r_c_beat;

    // ---------------- assertions ----------------
    a_no_load_in_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |-> (r_a_ctrl.op != OP_LOAD_ROW))
        else $error("load beat entered the pipeline");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_a_vld && r_b_vld && r_c_vld))
        else $error("input refused with a free stage");

    a_b_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && !c_take) |=> (r_b_vld && $stable(r_b_ctrl)))
        else $error("product stage lost a stalled beat");

    a_load_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_load |=> (r_mat[$past(i_in.data.row_index)][0] == $past(i_in.data.elem0)))
        else $error("row load not written");

endmodule
